// ===== hw/rtl/hhdm_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the heading-hold drive mixer.
package hhdm_pkg;

    localparam int CW = 28;
    localparam int ZW = 32;
    localparam int MAX_STEPS = 24;

    localparam logic [15:0] FULL_TURN = 16'd36000;
    localparam logic [15:0] HALF_TURN = 16'd18000;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [14:0] THRESH_RESET = 15'd500;

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [7:0] fwd;
        logic [15:0]       heading;
        logic              active;
        logic              half;
    } side_t;

    typedef struct packed {
        logic [15:0] heading_gain;
        logic [14:0] slow_threshold;
    } cfg_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int step);
        logic signed [ZW-1:0] r;
        case (step)
            0:       r = 32'sd294912000;
            1:       r = 32'sd174096719;
            2:       r = 32'sd91987925;
            3:       r = 32'sd46694507;
            4:       r = 32'sd23437865;
            5:       r = 32'sd11730358;
            6:       r = 32'sd5866610;
            7:       r = 32'sd2933484;
            8:       r = 32'sd1466764;
            9:       r = 32'sd733385;
            10:      r = 32'sd366693;
            11:      r = 32'sd183346;
            12:      r = 32'sd91673;
            13:      r = 32'sd45837;
            14:      r = 32'sd22918;
            15:      r = 32'sd11459;
            16:      r = 32'sd5730;
            17:      r = 32'sd2865;
            18:      r = 32'sd1432;
            19:      r = 32'sd716;
            20:      r = 32'sd358;
            21:      r = 32'sd179;
            22:      r = 32'sd90;
            23:      r = 32'sd45;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/heading_hold_drive_mixer.sv =====
// Top level of the heading-hold drive mixer: pipeline, output skid register and APB registers.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  stick x, stick y, forward stick, heading
//  m_*       out        m_tvalid / m_tready  left drive, right drive
//  APB       in         psel/penable/pready  heading_gain at 0x0, slow_threshold at 0x4
//
// One word is accepted every cycle while the skid register is empty.
// The pipeline holds one register per CORDIC micro-rotation plus seven stages around it:
// the input register, which loads at the accepting edge, five mixing stages and the output.
// Reset clears only the valid bits and the output and skid registers, and sets the configuration to its defaults.
// A stall freezes the whole pipeline once the skid register is occupied; s_tready is
// a register output and does not depend on m_tready within the same cycle.
module heading_hold_drive_mixer
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // right_stick_x, right_stick_y, forward_stick, robot_heading
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // left_drive, right_drive
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hhdm_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                           (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;

    cfg_t              cfg;
    logic              en;
    logic              cordic_valid;
    vec_t              cordic_vec;
    side_t             cordic_side;
    logic              mix_valid;
    logic signed [7:0] mix_left;
    logic signed [7:0] mix_right;

    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic              skid_valid_reg;
    logic [15:0]       skid_data_reg;

    assign en = !skid_valid_reg;
    assign s_tready = en;

    hhdm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hhdm_cordic #(
        .STEPS (STEPS)
    ) u_cordic (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .right_stick_x (s_tdata[7:0]),
        .right_stick_y (s_tdata[15:8]),
        .forward_stick (s_tdata[23:16]),
        .robot_heading (s_tdata[39:24]),
        .out_valid     (cordic_valid),
        .out_vec       (cordic_vec),
        .out_side      (cordic_side)
    );

    hhdm_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .cfg         (cfg),
        .in_valid    (cordic_valid),
        .in_vec      (cordic_vec),
        .in_side     (cordic_side),
        .out_valid   (mix_valid),
        .left_drive  (mix_left),
        .right_drive (mix_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            skid_valid_reg <= 1'b0;
            skid_data_reg <= '0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= mix_valid;
                out_data_reg <= {mix_right, mix_left};
            end
        end
        else if (en && mix_valid)
        begin
            skid_valid_reg <= 1'b1;
            skid_data_reg <= {mix_right, mix_left};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

// ===== hw/rtl/hhdm_apb_regs.sv =====
// Configuration register file behind the APB port.
module hhdm_apb_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output hhdm_pkg::cfg_t     cfg
);
    import hhdm_pkg::*;

    logic [15:0] gain_reg;
    logic [14:0] thresh_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_GAIN:   gain_reg <= pwdata[15:0];
                REG_THRESH: thresh_reg <= pwdata[14:0];
                default:    gain_reg <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GAIN:   prdata = {16'h0, gain_reg};
            REG_THRESH: prdata = {17'h0, thresh_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.heading_gain = gain_reg;
    assign cfg.slow_threshold = thresh_reg;

endmodule

// ===== hw/rtl/hhdm_cordic_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC.
module hhdm_cordic_stage
#(
    parameter int STEP = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  hhdm_pkg::vec_t    in_vec,
    input  hhdm_pkg::side_t   in_side,
    output logic              out_valid,
    output hhdm_pkg::vec_t    out_vec,
    output hhdm_pkg::side_t   out_side
);
    import hhdm_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_q16(STEP);

    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [ZW-1:0] z_in;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;
    logic                 b_pos;
    vec_t                 vec_next;
    logic                 valid_reg;
    vec_t                 vec_reg;
    side_t                side_reg;

    always_comb
    begin
        a_in = in_vec.a;
        b_in = in_vec.b;
        z_in = in_vec.z;
        da = b_in >>> STEP;
        db = a_in >>> STEP;
        b_pos = !b_in[CW-1] && (b_in != '0);
        if (b_pos)
        begin
            vec_next.a = a_in + da;
            vec_next.b = b_in - db;
            vec_next.z = z_in + ANGLE;
        end
        else
        begin
            vec_next.a = a_in - da;
            vec_next.b = b_in + db;
            vec_next.z = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec = vec_reg;
    assign out_side = side_reg;

endmodule

// ===== hw/rtl/hhdm_cordic.sv =====
// Input conditioning stage followed by the chain of CORDIC micro-rotation stages.
module hhdm_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [7:0] right_stick_x,
    input  logic signed [7:0] right_stick_y,
    input  logic signed [7:0] forward_stick,
    input  logic [15:0]       robot_heading,
    output logic              out_valid,
    output hhdm_pkg::vec_t    out_vec,
    output hhdm_pkg::side_t   out_side
);
    import hhdm_pkg::*;

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic                 small_x;
    logic                 small_y;
    vec_t                 vec_next;
    side_t                side_next;
    logic                 valid_reg;
    vec_t                 vec_reg;
    side_t                side_reg;

    logic                 chain_valid [STEPS+1];
    vec_t                 chain_vec [STEPS+1];
    side_t                chain_side [STEPS+1];

    always_comb
    begin
        x_ext = {{(CW-24){right_stick_x[7]}}, right_stick_x, 16'h0};
        y_ext = {{(CW-24){right_stick_y[7]}}, right_stick_y, 16'h0};
        small_x = (right_stick_x == 8'h00) || (right_stick_x == 8'h01) ||
                  (right_stick_x == 8'hFF);
        small_y = (right_stick_y == 8'h00) || (right_stick_y == 8'h01) ||
                  (right_stick_y == 8'hFF);
        if (right_stick_y[7])
        begin
            vec_next.a = -y_ext;
            vec_next.b = -x_ext;
        end
        else
        begin
            vec_next.a = y_ext;
            vec_next.b = x_ext;
        end
        vec_next.z = '0;
        side_next.fwd = forward_stick;
        side_next.heading = (robot_heading >= FULL_TURN) ? robot_heading - FULL_TURN
                                                         : robot_heading;
        side_next.active = !(small_x && small_y &&
                             ((right_stick_x == 8'h00) || (right_stick_y == 8'h00)));
        side_next.half = right_stick_y[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            side_reg <= side_next;
        end
    end

    assign chain_valid[0] = valid_reg;
    assign chain_vec[0] = vec_reg;
    assign chain_side[0] = side_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        hhdm_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    assign out_valid = chain_valid[STEPS];
    assign out_vec = chain_vec[STEPS];
    assign out_side = chain_side[STEPS];

endmodule

// ===== hw/rtl/hhdm_mix.sv =====
// Target wrap, heading error, gain multiply, mixing and saturation pipeline.
module hhdm_mix
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  hhdm_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  hhdm_pkg::vec_t    in_vec,
    input  hhdm_pkg::side_t   in_side,
    output logic              out_valid,
    output logic signed [7:0] left_drive,
    output logic signed [7:0] right_drive
);
    import hhdm_pkg::*;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 v5_reg;

    logic signed [ZW-1:0] zsum;
    logic signed [16:0]   ang;
    logic [15:0]          target_next;
    logic [15:0]          target_reg;
    logic [15:0]          head1_reg;
    logic signed [7:0]    fwd1_reg;

    logic signed [16:0]   diff;
    logic signed [15:0]   err_reg;
    logic                 slow_reg;
    logic signed [7:0]    fwd2_reg;

    logic signed [32:0]   turn_full;
    logic signed [22:0]   fwd_ext;
    logic signed [22:0]   fterm_next;
    logic signed [31:0]   turn_reg;
    logic signed [22:0]   fterm_reg;

    logic signed [31:0]   fterm_ext;
    logic signed [31:0]   num_reg [2];

    logic [31:0]          mag [2];
    logic [23:0]          hi [2];
    logic                 neg_reg [2];
    logic                 sat_reg [2];
    logic [26:0]          prod_reg [2];
    logic [6:0]           q [2];
    logic signed [7:0]    drive [2];

    always_comb
    begin
        zsum = in_vec.z + 32'sd32768;
        ang = {zsum[ZW-1], zsum[ZW-1:16]} + (in_side.half ? $signed({1'b0, HALF_TURN})
                                                          : 17'sd0);
        if (ang < 17'sd0)
        begin
            ang = ang + $signed({1'b0, FULL_TURN});
        end
        else if (ang >= $signed({1'b0, FULL_TURN}))
        begin
            ang = ang - $signed({1'b0, FULL_TURN});
        end
        target_next = in_side.active ? ang[15:0] : in_side.heading;
    end

    always_comb
    begin
        diff = $signed({1'b0, target_reg}) - $signed({1'b0, head1_reg});
        if (diff > $signed({1'b0, HALF_TURN}))
        begin
            diff = diff - $signed({1'b0, FULL_TURN});
        end
        else if (diff < -$signed({1'b0, HALF_TURN}))
        begin
            diff = diff + $signed({1'b0, FULL_TURN});
        end
    end

    always_comb
    begin
        turn_full = err_reg * $signed({1'b0, cfg.heading_gain});
        fwd_ext = {{15{fwd2_reg[7]}}, fwd2_reg};
        fterm_next = slow_reg ? fwd_ext * 23'sd12800 : fwd_ext * 23'sd25600;
        fterm_ext = {{9{fterm_reg[22]}}, fterm_reg};
    end

    for (genvar s = 0; s < 2; s++)
    begin : g_side
        always_comb
        begin
            mag[s] = num_reg[s][31] ? 32'(-num_reg[s]) : 32'(num_reg[s]);
            hi[s] = mag[s][31:8];
            q[s] = sat_reg[s] ? 7'd127 : prod_reg[s][25:19];
            drive[s] = neg_reg[s] ? -$signed({1'b0, q[s]}) : $signed({1'b0, q[s]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[s] <= num_reg[s][31];
                sat_reg[s] <= hi[s] >= 24'd12800;
                prod_reg[s] <= 27'(hi[s][13:0]) * 27'd5243;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            target_reg <= target_next;
            head1_reg <= in_side.heading;
            fwd1_reg <= in_side.fwd;
            err_reg <= diff[15:0];
            slow_reg <= diff > $signed({2'b0, cfg.slow_threshold});
            fwd2_reg <= fwd1_reg;
            turn_reg <= turn_full[31:0];
            fterm_reg <= fterm_next;
            num_reg[0] <= turn_reg + fterm_ext;
            num_reg[1] <= fterm_ext - turn_reg;
        end
    end

    assign out_valid = v5_reg;
    assign left_drive = drive[0];
    assign right_drive = drive[1];

endmodule
